[src/valve_command_frame_matcher_unit_assert.svh]
// Assertion macros shared by the matcher RTL.
// Each macro expects clk and rst_n in scope.
`ifndef VALVE_COMMAND_FRAME_MATCHER_UNIT_ASSERT_SVH
`define VALVE_COMMAND_FRAME_MATCHER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define VCFM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vcfm: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define VCFM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vcfm: next-cycle check failed");

`endif

[src/vcfm_pkg.sv]
package vcfm_pkg;

    // Window geometry
    localparam int WINDOW_DEPTH = 8;
    localparam int FIXED_LEN    = 7;
    localparam int PAIR_LEN     = 8;
    localparam int FILL_W       = 3;   // kept fill never exceeds seven

    // Frame bytes
    localparam logic [7:0] SOF_BYTE   = 8'hBB;
    localparam logic [7:0] FIX_HDR    = 8'h01;
    localparam logic [7:0] PAIR_HDR   = 8'h02;
    localparam logic [7:0] ACT_OPEN   = 8'h01;
    localparam logic [7:0] SUM_OPEN   = 8'h03;
    localparam logic [7:0] ACT_CLOSE  = 8'h02;
    localparam logic [7:0] SUM_CLOSE  = 8'h04;
    localparam logic [7:0] ACT_STOP   = 8'h00;
    localparam logic [7:0] SUM_STOP   = 8'h02;
    localparam logic [7:0] TRAIL_CR   = 8'h0D;
    localparam logic [7:0] TRAIL_LF   = 8'h0A;

    // Event codes
    localparam logic [1:0] EV_OPEN   = 2'd0;
    localparam logic [1:0] EV_CLOSE  = 2'd1;
    localparam logic [1:0] EV_STOP   = 2'd2;
    localparam logic [1:0] EV_PAIRED = 2'd3;

    typedef logic [WINDOW_DEPTH-1:0][7:0] window_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       pairing_mode;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  event_code;
        logic [15:0] paired_id;
        logic [7:0]  frames_seen;
    } out_item_t;

    // Outcome of one byte through the matcher
    typedef struct packed {
        logic              hit;
        logic [1:0]        event_code;
        logic [15:0]       paired_id;
        window_t           window_next;
        logic [FILL_W-1:0] fill_next;
    } step_t;

endpackage

[src/vcfm_match.sv]
module vcfm_match (
    input  vcfm_pkg::window_t              window,
    input  logic [vcfm_pkg::FILL_W-1:0]    fill,
    input  vcfm_pkg::in_item_t             item,
    output vcfm_pkg::step_t                step
);

    localparam logic [vcfm_pkg::FILL_W-1:0] FILL_W_ONE = 1;

    // Test a 7-byte slice against open, close and stop; returns {hit, code}
    function automatic logic [2:0] fixed_check(input logic [6:0][7:0] s);
        logic       head_ok;
        logic [2:0] res;
        head_ok = (s[0] == vcfm_pkg::SOF_BYTE) && (s[1] == vcfm_pkg::FIX_HDR) &&
                  (s[2] == vcfm_pkg::FIX_HDR) && (s[5] == vcfm_pkg::TRAIL_CR) &&
                  (s[6] == vcfm_pkg::TRAIL_LF);
        res = '0;
        if (head_ok && s[3] == vcfm_pkg::ACT_OPEN && s[4] == vcfm_pkg::SUM_OPEN)
            res = {1'b1, vcfm_pkg::EV_OPEN};
        else if (head_ok && s[3] == vcfm_pkg::ACT_CLOSE && s[4] == vcfm_pkg::SUM_CLOSE)
            res = {1'b1, vcfm_pkg::EV_CLOSE};
        else if (head_ok && s[3] == vcfm_pkg::ACT_STOP && s[4] == vcfm_pkg::SUM_STOP)
            res = {1'b1, vcfm_pkg::EV_STOP};
        return res;
    endfunction

    vcfm_pkg::window_t cand;
    logic [3:0]        count;
    logic [2:0]        fix_old;
    logic [2:0]        fix_new;
    logic [7:0]        pair_sum;
    logic              pair_ok;

    // Candidate window: new byte appended at the young end
    always_comb
    begin
        cand       = window;
        cand[fill] = item.rx_byte;
    end

    assign count    = {1'b0, fill} + 4'd1;
    assign fix_old  = fixed_check(cand[6:0]);
    assign fix_new  = fixed_check(cand[7:1]);
    assign pair_sum = cand[1] + cand[2] + cand[3] + cand[4];
    assign pair_ok  = (cand[0] == vcfm_pkg::SOF_BYTE) && (cand[1] == vcfm_pkg::PAIR_HDR) &&
                      (cand[2] == vcfm_pkg::PAIR_HDR) && (cand[6] == vcfm_pkg::TRAIL_CR) &&
                      (cand[7] == vcfm_pkg::TRAIL_LF) && (pair_sum == cand[5]);

    // Match from the oldest byte, dropping at most two bytes per transfer
    always_comb
    begin
        step             = '0;
        step.window_next = cand;
        step.fill_next   = count[vcfm_pkg::FILL_W-1:0];
        priority if (count == 4'(vcfm_pkg::PAIR_LEN))
        begin
            priority if (fix_old[2])
            begin
                step.hit         = 1'b1;
                step.event_code  = fix_old[1:0];
                step.window_next = vcfm_pkg::window_t'(cand >> (8 * vcfm_pkg::FIXED_LEN));
                step.fill_next   = FILL_W_ONE;
            end
            else if (item.pairing_mode && pair_ok)
            begin
                step.hit        = 1'b1;
                step.event_code = vcfm_pkg::EV_PAIRED;
                step.paired_id  = {cand[3], cand[4]};
                step.fill_next  = '0;
            end
            else if (fix_new[2])
            begin
                step.hit        = 1'b1;
                step.event_code = fix_new[1:0];
                step.fill_next  = '0;
            end
            else if (item.pairing_mode)
            begin
                // keep seven bytes and wait for a possible pairing frame
                step.window_next = vcfm_pkg::window_t'(cand >> 8);
                step.fill_next   = 3'(vcfm_pkg::FIXED_LEN);
            end
            else
            begin
                step.window_next = vcfm_pkg::window_t'(cand >> 16);
                step.fill_next   = 3'(vcfm_pkg::FIXED_LEN - 1);
            end
        end
        else if (count == 4'(vcfm_pkg::FIXED_LEN))
        begin
            priority if (fix_old[2])
            begin
                step.hit        = 1'b1;
                step.event_code = fix_old[1:0];
                step.fill_next  = '0;
            end
            else if (item.pairing_mode)
            begin
                step.fill_next = 3'(vcfm_pkg::FIXED_LEN);
            end
            else
            begin
                step.window_next = vcfm_pkg::window_t'(cand >> 8);
                step.fill_next   = 3'(vcfm_pkg::FIXED_LEN - 1);
            end
        end
        else
        begin
            step.fill_next = count[vcfm_pkg::FILL_W-1:0];
        end
    end

endmodule

[src/valve_command_frame_matcher_unit.sv]
// Valve command frame matcher. Takes one received byte per transfer and
// matches the open, close and stop frames (BB 01 01 cmd sum 0D 0A) and, in
// pairing mode, the pairing frame BB 02 02 idH idL sum 0D 0A. A match yields
// one result carrying the event, the 16-bit id of a pairing frame and the
// wrapping count of frames matched so far. Rate: one byte per clock cycle
// while the output queue has room; the window update and all frame compares
// are done in the cycle the byte is taken, and the result is registered into
// a two-entry output queue. Input ready drops only while that queue is full,
// so a stalled consumer holds the input back after two pending results.
`include "valve_command_frame_matcher_unit_assert.svh"

module valve_command_frame_matcher_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vcfm_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output vcfm_pkg::out_item_t out_data
);

    vcfm_pkg::window_t               window_reg;
    logic [vcfm_pkg::FILL_W-1:0]     fill_reg;
    logic [7:0]                      frame_counter_reg;
    logic [7:0]                      frame_counter_next;
    vcfm_pkg::step_t                 step;
    vcfm_pkg::out_item_t             slot0_reg;
    vcfm_pkg::out_item_t             slot1_reg;
    vcfm_pkg::out_item_t             slot0_next;
    vcfm_pkg::out_item_t             slot1_next;
    vcfm_pkg::out_item_t             new_item;
    logic [1:0]                      count_reg;
    logic [1:0]                      count_next;
    logic                            in_xfer;
    logic                            push;
    logic                            pop;

    vcfm_match u_match (
        .window (window_reg),
        .fill   (fill_reg),
        .item   (in_data),
        .step   (step)
    );

    assign in_ready  = (count_reg != 2'd2);
    assign in_xfer   = in_valid && in_ready;
    assign push      = in_xfer && step.hit;
    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot0_reg;

    assign frame_counter_next = frame_counter_reg + 8'd1;

    always_comb
    begin
        new_item.event_code  = step.event_code;
        new_item.paired_id   = step.paired_id;
        new_item.frames_seen = frame_counter_next;
    end

    // Output queue: slot0 is the head
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        unique case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                    slot0_next = new_item;
                else
                    slot1_next = new_item;
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                slot0_next = slot1_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                    slot0_next = new_item;
                else
                begin
                    slot0_next = slot1_reg;
                    slot1_next = new_item;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg          <= '0;
            frame_counter_reg <= '0;
            count_reg         <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_xfer)
            begin
                fill_reg <= step.fill_next;
                if (step.hit)
                    frame_counter_reg <= frame_counter_next;
            end
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
        if (in_xfer)
            window_reg <= step.window_next;
    end

    `VCFM_ASSERT_NEXT(a_count_on_hit, in_xfer && step.hit, frame_counter_reg == $past(frame_counter_next))
    `VCFM_ASSERT_NEXT(a_count_hold, in_xfer && !step.hit, $stable(frame_counter_reg))
    `VCFM_ASSERT_NEXT(a_keep_seven_pairing, in_xfer && !in_data.pairing_mode && !step.hit, fill_reg != 3'd7)
    `VCFM_ASSERT_SAME(a_queue_bound, 1'b1, count_reg != 2'd3)

endmodule
